@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define SDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define SDS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `SDS_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

@@ rtl/core/sds_pkg.sv @@
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants of the SCAN disk scheduler.
// ----------------------------------------------------------------------------
package sds_pkg;

   localparam int DEF_MAX_QUEUE = 32;

   localparam int CYL_W  = 16;
   localparam int DISK_W = 17;
   localparam int SEEK_W = 24;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_START = 1'b1;

   localparam logic [1:0] CSR_DISK_CYLINDERS = 2'd0;
   localparam logic [1:0] CSR_START_HEAD     = 2'd1;
   localparam logic [1:0] CSR_SWEEP_RIGHT    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BND_LO,
      ST_BND_HI,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_SEND
   } sds_state_type;

   typedef struct packed {
      logic load_wr;
      logic bnd_lo_wr;
      logic bnd_hi_wr;
      logic run_init;
      logic scan_start;
      logic scan_step;
      logic phase_flip;
      logic eval_out;
      logic out_ack;
      logic run_clear;
   } sds_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic last;
   } sds_sts_type;

   // upper boundary cylinder with the cylinder count clamped to 1..65536
   function automatic logic [CYL_W-1:0] upper_bound(input logic [DISK_W-1:0] cyl);
      logic [CYL_W-1:0] res;
      if (cyl == '0) begin
         res = '0;
      end else if (cyl[DISK_W-1]) begin
         res = '1;
      end else begin
         res = cyl[CYL_W-1:0] - CYL_W'(1);
      end
      return res;
   endfunction

endpackage

@@ rtl/core/sds_ctrl.sv @@
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer: loads, boundary insert, per-visit store scan and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sds_ctrl import sds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  sds_sts_type sts,
   output sds_cmd_type cmd
);

   sds_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_type == REQ_START) state_in = ST_BND_LO;
         end
         ST_BND_LO: state_in = ST_BND_HI;
         ST_BND_HI: state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = sts.found ? ST_SEND : ST_SCAN;
         end
         ST_SEND: begin
            if (!rsp_stall) state_in = sts.last ? ST_IDLE : ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_wr  = (req_type == REQ_LOAD);
               cmd.run_init = (req_type == REQ_START);
            end
         end
         ST_BND_LO: cmd.bnd_lo_wr = 1'b1;
         ST_BND_HI: begin
            cmd.bnd_hi_wr  = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ST_SCAN: cmd.scan_step = 1'b1;
         ST_DRAIN: ;
         ST_EVAL: begin
            if (sts.found) begin
               cmd.eval_out = 1'b1;
            end else begin
               cmd.phase_flip = 1'b1;
               cmd.scan_start = 1'b1;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.out_ack    = 1'b1;
               cmd.run_clear  = sts.last;
               cmd.scan_start = !sts.last;
            end
         end
         default: ;
      endcase
   end

   `SDS_ASSERT(a_last_to_idle, clock, reset, (state_ff == ST_SEND && !rsp_stall && sts.last) |=> (state_ff == ST_IDLE), "run did not end after final word")
   `SDS_ASSERT(a_scan_ends, clock, reset, (state_ff == ST_DRAIN) |-> $past(sts.scan_last), "scan left early")

endmodule

@@ rtl/core/sds_dpath.sv @@
// ----------------------------------------------------------------------------
// sds_dpath
// Request store, ordered next-entry search, head and seek bookkeeping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sds_dpath import sds_pkg::*; #(
   parameter int MAX_QUEUE = DEF_MAX_QUEUE
) (
   input  logic              clock,
   input  logic              reset,
   input  sds_cmd_type       cmd,
   output sds_sts_type       sts,
   input  logic [CYL_W-1:0]  req_cylinder,
   input  logic [DISK_W-1:0] disk_cylinders,
   input  logic [CYL_W-1:0]  start_head,
   input  logic              sweep_right,
   output logic [CYL_W-1:0]  rsp_position,
   output logic [SEEK_W-1:0] rsp_seek_total,
   output logic              rsp_last
);

   localparam int Depth = MAX_QUEUE + 2;
   localparam int IW    = $clog2(Depth);
   localparam int KW    = $clog2(Depth + 1);
   localparam int KeyW  = CYL_W + IW;

   logic [CYL_W-1:0]  mem [Depth];

   logic [IW-1:0]     count_ff, count_in;
   logic [IW-1:0]     scan_addr_ff, scan_addr_in;
   logic [IW-1:0]     rd_idx_ff;
   logic              rd_valid_ff;
   logic [CYL_W-1:0]  rd_data_ff;
   logic              best_valid_ff, best_valid_in;
   logic [KeyW-1:0]   best_key_ff, best_key_in;
   logic [KeyW-1:0]   thr_key_ff, thr_key_in;
   logic              asc_ff, asc_in;
   logic              first_ff, first_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [CYL_W-1:0]  head_ff, head_in;
   logic [SEEK_W-1:0] accum_ff, accum_in;
   logic [CYL_W-1:0]  pos_ff, pos_in;
   logic [SEEK_W-1:0] seek_ff, seek_in;
   logic              last_ff, last_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [CYL_W-1:0]  wr_data;
   logic              full;
   logic [KeyW-1:0]   cand_key;
   logic              cand_ok;
   logic              better;
   logic [CYL_W-1:0]  best_v;
   logic [CYL_W-1:0]  seek_step;

   assign full      = (count_ff == IW'(MAX_QUEUE));
   assign cand_key  = {rd_data_ff, rd_idx_ff};
   assign best_v    = best_key_ff[KeyW-1 -: CYL_W];
   assign seek_step = (best_v > head_ff) ? (best_v - head_ff) : (head_ff - best_v);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff;
      wr_data = req_cylinder;
      if (cmd.load_wr && !full) begin
         wr_en = 1'b1;
      end else if (cmd.bnd_lo_wr) begin
         wr_en   = 1'b1;
         wr_data = '0;
      end else if (cmd.bnd_hi_wr) begin
         wr_en   = 1'b1;
         wr_addr = count_ff + IW'(1);
         wr_data = upper_bound(disk_cylinders);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.scan_step) begin
         rd_data_ff <= mem[scan_addr_ff];
         rd_idx_ff  <= scan_addr_ff;
      end
   end

   always_comb begin
      if (asc_ff) begin
         cand_ok = first_ff ? (rd_data_ff > start_head) : (cand_key > thr_key_ff);
         better  = !best_valid_ff || (cand_key < best_key_ff);
      end else begin
         cand_ok = first_ff ? (rd_data_ff <= start_head) : (cand_key < thr_key_ff);
         better  = !best_valid_ff || (cand_key > best_key_ff);
      end
   end

   always_comb begin
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      thr_key_in    = thr_key_ff;
      asc_in        = asc_ff;
      first_in      = first_ff;
      k_in          = k_ff;
      head_in       = head_ff;
      accum_in      = accum_ff;
      pos_in        = pos_ff;
      seek_in       = seek_ff;
      last_in       = last_ff;

      if (cmd.load_wr && !full) count_in = count_ff + IW'(1);
      if (cmd.run_clear) count_in = '0;

      if (cmd.run_init) begin
         head_in  = start_head;
         accum_in = '0;
         k_in     = '0;
         first_in = 1'b1;
         asc_in   = sweep_right;
      end

      if (cmd.phase_flip) begin
         asc_in   = !asc_ff;
         first_in = 1'b1;
      end

      if (rd_valid_ff && cand_ok && better) begin
         best_valid_in = 1'b1;
         best_key_in   = cand_key;
      end

      if (cmd.scan_start) begin
         scan_addr_in  = '0;
         best_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         scan_addr_in = scan_addr_ff + IW'(1);
      end

      if (cmd.eval_out) begin
         pos_in  = best_v;
         seek_in = accum_ff + SEEK_W'(seek_step);
         last_in = (k_ff == KW'(count_ff) + KW'(1));
      end

      if (cmd.out_ack) begin
         accum_in   = seek_ff;
         head_in    = pos_ff;
         thr_key_in = best_key_ff;
         first_in   = 1'b0;
         k_in       = k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         asc_ff        <= 1'b1;
         first_ff      <= 1'b1;
         k_ff          <= '0;
      end else begin
         count_ff      <= count_in;
         rd_valid_ff   <= cmd.scan_step;
         best_valid_ff <= best_valid_in;
         asc_ff        <= asc_in;
         first_ff      <= first_in;
         k_ff          <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      best_key_ff  <= best_key_in;
      thr_key_ff   <= thr_key_in;
      head_ff      <= head_in;
      accum_ff     <= accum_in;
      pos_ff       <= pos_in;
      seek_ff      <= seek_in;
      last_ff      <= last_in;
   end

   assign sts.scan_last = (scan_addr_ff == count_ff + IW'(1));
   assign sts.found     = best_valid_ff;
   assign sts.last      = last_ff;

   assign rsp_position   = pos_ff;
   assign rsp_seek_total = seek_ff;
   assign rsp_last       = last_ff;

   `SDS_ASSERT_NEVER(a_count_cap, clock, reset, count_ff > IW'(MAX_QUEUE),
                     "store count above capacity")
   `SDS_ASSERT(a_scan_bound, clock, reset,
               cmd.scan_step |-> (scan_addr_ff <= count_ff + IW'(1)),
               "scan read past boundaries")
   `SDS_ASSERT(a_eval_found, clock, reset, cmd.eval_out |-> best_valid_ff,
               "result loaded without a match")

endmodule

@@ rtl/core/scan_disk_scheduler.sv @@
// ----------------------------------------------------------------------------
// scan_disk_scheduler
// SCAN (elevator) disk scheduler with load-then-run request store.
// ----------------------------------------------------------------------------
// Load words are accepted while idle and may stream back to back. A start
// word inserts the two boundary cylinders and then produces one result word
// per store scan. Each scan reads every stored request and both boundaries
// through the single read port of the request store, then takes a compare
// drain, a select and a send that waits while rsp_stall is high; where the
// sweep turns, one extra empty scan finds no match. The block takes no new
// word until the final result of a run has been taken.

module scan_disk_scheduler import sds_pkg::*; #(
   parameter int MAX_QUEUE = DEF_MAX_QUEUE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [CYL_W-1:0]  req_cylinder,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CYL_W-1:0]  rsp_position,
   output logic [SEEK_W-1:0] rsp_seek_total,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [DISK_W-1:0] csr_data
);

   logic [DISK_W-1:0] disk_cyl_ff;
   logic [CYL_W-1:0]  start_head_ff;
   logic              sweep_right_ff;
   sds_cmd_type       cmd;
   sds_sts_type       sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_cyl_ff    <= DISK_W'(65536);
         start_head_ff  <= '0;
         sweep_right_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DISK_CYLINDERS: disk_cyl_ff    <= csr_data;
            CSR_START_HEAD:     start_head_ff  <= csr_data[CYL_W-1:0];
            CSR_SWEEP_RIGHT:    sweep_right_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   sds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sds_dpath #(
      .MAX_QUEUE (MAX_QUEUE)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_cylinder   (req_cylinder),
      .disk_cylinders (disk_cyl_ff),
      .start_head     (start_head_ff),
      .sweep_right    (sweep_right_ff),
      .rsp_position   (rsp_position),
      .rsp_seek_total (rsp_seek_total),
      .rsp_last       (rsp_last)
   );

endmodule
